[hw/rtl/lld_pkg.sv]
package lld_pkg;

   localparam int MAX_WORKERS_DEF = 16;
   localparam int MAX_ORDER_DEF   = 64;

   localparam logic [1:0] KIND_ORDER = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;

   localparam logic [2:0] STAT_DISPATCHED = 3'd0;
   localparam logic [2:0] STAT_DROPPED    = 3'd1;
   localparam logic [2:0] STAT_APPLIED    = 3'd2;
   localparam logic [2:0] STAT_UNKNOWN    = 3'd3;
   localparam logic [2:0] STAT_CLOSED     = 3'd4;

   localparam logic [7:0] COOKS_RESET = 8'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] job_type;
      logic [7:0] job_size;
      logic [6:0] job_count;
      logic [4:0] worker_id;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] target_id;
      logic [7:0] out_type;
      logic [7:0] out_size;
      logic       opened_worker;
      logic [6:0] undelivered;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic scan_clear;
      logic scan_step;
      logic dispatch;
      logic apply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_order;
      logic is_worker_op;
      logic count_zero;
      logic scan_done;
      logic dispatch_ok;
      logic count_one;
      logic rsp_free;
   } dp_stat_type;

endpackage

[hw/rtl/lld_ctrl.sv]
module lld_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  lld_pkg::dp_stat_type  stat,
   output lld_pkg::ctrl_cmd_type cmd
);
   import lld_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SCAN     = 3'd2;
   localparam logic [2:0] S_SETTLE   = 3'd3;
   localparam logic [2:0] S_DISPATCH = 3'd4;
   localparam logic [2:0] S_LOOKUP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_order && !stat.count_zero) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN;
            end else if (stat.is_worker_op) begin
               state_in = S_LOOKUP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (stat.rsp_free) begin
               cmd.dispatch = 1'b1;
               if (!stat.dispatch_ok || stat.count_one) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.scan_clear = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_LOOKUP: begin
            if (stat.rsp_free) begin
               cmd.apply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/lld_datapath.sv]
module lld_datapath #(
   parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
   parameter int MAX_ORDER   = lld_pkg::MAX_ORDER_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lld_pkg::ctrl_cmd_type cmd,
   output lld_pkg::dp_stat_type  stat,
   input  lld_pkg::req_type      req_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [7:0]            csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lld_pkg::rsp_type      rsp_data
);
   import lld_pkg::*;

   localparam int               IDX_W     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam logic [8:0]       WORKERS_V = 9'(MAX_WORKERS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MAX_WORKERS - 1);
   localparam logic [6:0]       ORDER_V   = 7'(MAX_ORDER);

   logic [8:0] load_mem [MAX_WORKERS];

   logic [7:0]             cooks_ff;
   req_type                item_ff;
   logic [6:0]             count_ff;
   logic [MAX_WORKERS-1:0] present_ff;
   logic [8:0]             rd_data_ff;
   logic [IDX_W-1:0]       scan_idx_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic                   rd_present_ff;
   logic                   found_ff;
   logic [8:0]             best_ff;
   logic [IDX_W-1:0]       best_idx_ff;
   logic                   free_found_ff;
   logic [IDX_W-1:0]       free_idx_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff;

   logic [4:0]       id_m1;
   logic [IDX_W-1:0] id_idx;
   logic             id_in_range;
   logic             known;
   logic [IDX_W-1:0] rd_addr;
   logic [8:0]       limit;
   logic             sel_best;
   logic             sel_open;
   logic [IDX_W-1:0] w_idx;
   logic [8:0]       w_load;
   logic [IDX_W:0]   w_num;
   logic [8:0]       dec_load;
   logic             rsp_free;
   logic [6:0]       count_sat;
   logic             done_op;

   assign id_m1       = item_ff.worker_id - 5'd1;
   assign id_idx      = IDX_W'(id_m1);
   assign id_in_range = (item_ff.worker_id != 5'd0) && ({4'b0, item_ff.worker_id} <= WORKERS_V);
   assign known       = id_in_range && present_ff[id_idx];
   assign done_op     = (item_ff.kind == KIND_DONE);
   assign rd_addr     = cmd.scan_step ? scan_idx_ff : id_idx;
   assign limit       = {cooks_ff, 1'b0};
   assign sel_best    = found_ff && (best_ff < limit);
   assign sel_open    = !sel_best && (cooks_ff != 8'd0) && free_found_ff;
   assign w_idx       = sel_best ? best_idx_ff : free_idx_ff;
   assign w_load      = sel_best ? (best_ff + 9'd1) : 9'd1;
   assign w_num       = {1'b0, w_idx} + {{IDX_W{1'b0}}, 1'b1};
   assign dec_load    = (rd_data_ff != 9'd0) ? (rd_data_ff - 9'd1) : rd_data_ff;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign count_sat   = (req_data.job_count > ORDER_V) ? ORDER_V : req_data.job_count;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      stat              = '0;
      stat.is_order     = (item_ff.kind == KIND_ORDER);
      stat.is_worker_op = done_op || (item_ff.kind == KIND_CLOSE);
      stat.count_zero   = (count_ff == 7'd0);
      stat.scan_done    = (scan_idx_ff == LAST_IDX);
      stat.dispatch_ok  = sel_best || sel_open;
      stat.count_one    = (count_ff == 7'd1);
      stat.rsp_free     = rsp_free;
   end

   // worker load table
   always_ff @(posedge clock) begin
      if (cmd.dispatch && (sel_best || sel_open)) begin
         load_mem[w_idx] <= w_load;
      end else if (cmd.apply && known && done_op) begin
         load_mem[id_idx] <= dec_load;
      end
      rd_data_ff <= load_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooks_ff      <= COOKS_RESET;
         present_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rd_valid_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         scan_idx_ff   <= '0;
      end else begin
         if (csr_valid) begin
            cooks_ff <= csr_data;
         end

         if (cmd.dispatch || cmd.apply) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (cmd.scan_clear) begin
            scan_idx_ff   <= '0;
            rd_valid_ff   <= 1'b0;
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else begin
            rd_valid_ff <= cmd.scan_step;
            if (cmd.scan_step) begin
               scan_idx_ff <= scan_idx_ff + IDX_W'(1);
            end
            if (rd_valid_ff) begin
               if (rd_present_ff) begin
                  if (!found_ff || (rd_data_ff < best_ff)) begin
                     found_ff <= 1'b1;
                  end
               end else if (!free_found_ff) begin
                  free_found_ff <= 1'b1;
               end
            end
         end

         if (cmd.dispatch) begin
            if (sel_open) begin
               present_ff[free_idx_ff] <= 1'b1;
            end
         end

         if (cmd.apply) begin
            if (known && !done_op) begin
               present_ff[id_idx] <= 1'b0;
            end
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff  <= req_data;
         count_ff <= count_sat;
      end

      if (cmd.scan_step) begin
         rd_idx_ff     <= scan_idx_ff;
         rd_present_ff <= present_ff[scan_idx_ff];
      end

      if (!cmd.scan_clear && rd_valid_ff) begin
         if (rd_present_ff) begin
            if (!found_ff || (rd_data_ff < best_ff)) begin
               best_ff     <= rd_data_ff;
               best_idx_ff <= rd_idx_ff;
            end
         end else if (!free_found_ff) begin
            free_idx_ff <= rd_idx_ff;
         end
      end

      if (cmd.dispatch) begin
         if (sel_best || sel_open) begin
            count_ff             <= count_ff - 7'd1;
            rsp_ff.status        <= STAT_DISPATCHED;
            rsp_ff.target_id     <= 5'(w_num);
            rsp_ff.out_type      <= item_ff.job_type;
            rsp_ff.out_size      <= item_ff.job_size;
            rsp_ff.opened_worker <= sel_open;
            rsp_ff.undelivered   <= 7'd0;
            rsp_ff.last          <= (count_ff == 7'd1);
         end else begin
            rsp_ff.status        <= STAT_DROPPED;
            rsp_ff.target_id     <= 5'd0;
            rsp_ff.out_type      <= 8'd0;
            rsp_ff.out_size      <= 8'd0;
            rsp_ff.opened_worker <= 1'b0;
            rsp_ff.undelivered   <= count_ff;
            rsp_ff.last          <= 1'b1;
         end
      end

      if (cmd.apply) begin
         if (!known) begin
            rsp_ff.status <= STAT_UNKNOWN;
         end else if (done_op) begin
            rsp_ff.status <= STAT_APPLIED;
         end else begin
            rsp_ff.status <= STAT_CLOSED;
         end
         rsp_ff.target_id     <= item_ff.worker_id;
         rsp_ff.out_type      <= 8'd0;
         rsp_ff.out_size      <= 8'd0;
         rsp_ff.opened_worker <= 1'b0;
         rsp_ff.undelivered   <= 7'd0;
         rsp_ff.last          <= 1'b1;
      end
   end

endmodule

[hw/rtl/least_loaded_dispatcher.sv]
// channel  direction  payload            handshake
// req      in         lld_pkg::req_type  req_valid / req_ready
// rsp      out        lld_pkg::rsp_type  rsp_valid / rsp_ready
// csr      in         cooks_per_worker   csr_valid / csr_ready (always ready)
//
// Each job of an order scans the worker table through the single read port of
// the load memory, after the item is accepted and decoded; no new item is taken
// until the current one is done. Completions and closes look up one worker only.
// Synchronous active-high reset empties the table and sets cooks_per_worker to 2.
// A stalled rsp holds one finished item; the next result waits for it to go.
module least_loaded_dispatcher #(
   parameter int MAX_WORKERS = lld_pkg::MAX_WORKERS_DEF,
   parameter int MAX_ORDER   = lld_pkg::MAX_ORDER_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lld_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_data
);
   import lld_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   lld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lld_datapath #(
      .MAX_WORKERS (MAX_WORKERS),
      .MAX_ORDER   (MAX_ORDER)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while an item is in progress");

   a_nondispatch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != STAT_DISPATCHED) |-> rsp_data.last)
      else $error("non-dispatch result not marked last");

   a_open_is_dispatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.opened_worker
      |-> (rsp_data.status == STAT_DISPATCHED) && (rsp_data.undelivered == 7'd0))
      else $error("opened worker flagged on a non-dispatch result");

endmodule

[bench/least_loaded_dispatcher_tb.sv]
`timescale 1ns / 100ps

module least_loaded_dispatcher_tb;
   import lld_pkg::*;

   localparam logic [1:0] KIND_UNDEF = 2'd3;
   localparam int NUM_WORKERS = MAX_WORKERS_DEF;
   localparam int ORDER_CAP   = MAX_ORDER_DEF;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 500;
   localparam int PHASE_ITEMS = 26;
   localparam longint CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic       is_cfg;
      logic [7:0] cooks;
      req_type    req;
      logic       typed;
      rsp_type    rsp;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [7:0] csr_data = '0;

   logic       worker_on [NUM_WORKERS];
   logic [8:0] worker_load [NUM_WORKERS];
   logic [7:0] cooks_setting;

   rsp_type     expected_rsp [$];
   rsp_type     step_out [$];
   dir_row_type dir_rows [$];

   int     errors = 0;
   int     items_sent = 0;
   int     results_seen = 0;
   int     drops_seen = 0;
   int     settings_used = 0;
   longint cycle_count = 0;
   logic   pressure_armed = 1'b0;
   logic   pressure_done = 1'b0;
   int     hold_left = 0;
   int     stall_left = 0;

   least_loaded_dispatcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type mk_req(int kind, int jtype, int jsize, int count, int id);
      req_type r;
      r.kind = 2'(kind);
      r.job_type = 8'(jtype);
      r.job_size = 8'(jsize);
      r.job_count = 7'(count);
      r.worker_id = 5'(id);
      return r;
   endfunction

   function automatic rsp_type mk_rsp(int status, int target, int jtype, int jsize,
                                      int opened, int undeliv);
      rsp_type x;
      x.status = 3'(status);
      x.target_id = 5'(target);
      x.out_type = 8'(jtype);
      x.out_size = 8'(jsize);
      x.opened_worker = 1'(opened);
      x.undelivered = 7'(undeliv);
      x.last = 1'b1;
      return x;
   endfunction

   // least-loaded dispatch of one accepted item into step_out
   function automatic void dispatch_step(input req_type r);
      int left;
      int w;
      int i;
      int limit;
      int best;
      logic opened;
      rsp_type x;
      step_out.delete();
      limit = 2 * int'(cooks_setting);
      if (r.kind == KIND_ORDER && r.job_count != 0) begin
         left = (int'(r.job_count) > ORDER_CAP) ? ORDER_CAP : int'(r.job_count);
         while (left > 0) begin
            w = -1;
            best = 32'h7FFF_FFFF;
            opened = 1'b0;
            for (i = 0; i < NUM_WORKERS; i++) begin
               if (worker_on[i] && int'(worker_load[i]) < best) begin
                  best = int'(worker_load[i]);
                  w = i;
               end
            end
            if (w >= 0 && best >= limit) w = -1;
            if (w < 0 && cooks_setting != 0) begin
               for (i = NUM_WORKERS - 1; i >= 0; i--) begin
                  if (!worker_on[i]) w = i;
               end
               if (w >= 0) begin
                  worker_on[w] = 1'b1;
                  worker_load[w] = '0;
                  opened = 1'b1;
               end
            end
            if (w < 0) break;
            worker_load[w] = worker_load[w] + 9'd1;
            x = mk_rsp(int'(STAT_DISPATCHED), w + 1, int'(r.job_type), int'(r.job_size),
                       int'(opened), 0);
            x.last = 1'b0;
            step_out.insert(step_out.size(), x);
            left--;
         end
         if (left > 0) begin
            x = mk_rsp(int'(STAT_DROPPED), 0, 0, 0, 0, left);
            x.last = 1'b0;
            step_out.insert(step_out.size(), x);
         end
         x = step_out.pop_back();
         x.last = 1'b1;
         step_out.insert(step_out.size(), x);
      end else if (r.kind == KIND_DONE || r.kind == KIND_CLOSE) begin
         w = int'(r.worker_id) - 1;
         if (w < 0 || w >= NUM_WORKERS || !worker_on[w]) begin
            step_out.insert(step_out.size(),
                            mk_rsp(int'(STAT_UNKNOWN), int'(r.worker_id), 0, 0, 0, 0));
         end else if (r.kind == KIND_DONE) begin
            if (worker_load[w] != 0) worker_load[w] = worker_load[w] - 9'd1;
            step_out.insert(step_out.size(),
                            mk_rsp(int'(STAT_APPLIED), int'(r.worker_id), 0, 0, 0, 0));
         end else begin
            worker_on[w] = 1'b0;
            worker_load[w] = '0;
            step_out.insert(step_out.size(),
                            mk_rsp(int'(STAT_CLOSED), int'(r.worker_id), 0, 0, 0, 0));
         end
      end
   endfunction

   function automatic req_type random_item();
      req_type r;
      int pick;
      int sel;
      int i;
      int ids [$];
      r = mk_req(KIND_ORDER, $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(1, 6), $urandom_range(0, 31));
      for (i = 0; i < NUM_WORKERS; i++) begin
         if (worker_on[i]) ids.insert(ids.size(), i + 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         sel = $urandom_range(0, 19);
         if (sel >= 19) r.job_count = 7'($urandom_range(65, 127));
         else if (sel >= 14) r.job_count = 7'($urandom_range(7, 64));
      end else if (pick < 88 && ids.size() > 0) begin
         r.kind = (pick < 75) ? KIND_DONE : KIND_CLOSE;
         r.worker_id = 5'(ids[$urandom_range(0, ids.size() - 1)]);
      end else begin
         sel = $urandom_range(0, 3);
         case (sel)
            0: r.kind = KIND_UNDEF;
            1: r.job_count = '0;
            2: r.kind = KIND_DONE;
            default: r.kind = KIND_CLOSE;
         endcase
      end
      return r;
   endfunction

   task automatic send_item(input req_type r, input logic typed, input rsp_type typed_rsp,
                            output int produced);
      int gap;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      dispatch_step(r);
      produced = step_out.size();
      items_sent++;
      if (typed) expected_rsp.insert(expected_rsp.size(), typed_rsp);
      else foreach (step_out[k]) expected_rsp.insert(expected_rsp.size(), step_out[k]);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_cooks(input logic [7:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cooks_setting = v;
      settings_used++;
   endtask

   task automatic add_op(input req_type r, input logic typed, input rsp_type x);
      dir_row_type row;
      row = '0;
      row.req = r;
      row.typed = typed;
      row.rsp = x;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic add_cfg(input logic [7:0] v);
      dir_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.cooks = v;
      dir_rows.insert(dir_rows.size(), row);
   endtask

   always @(posedge clock) begin : rsp_side
      rsp_type want;
      logic bad;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.status == STAT_DROPPED) drops_seen++;
            if (expected_rsp.size() == 0) begin
               $error("result with nothing expected: status %0d target %0d",
                      rsp_data.status, rsp_data.target_id);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               bad = 1'b0;
               if (rsp_data.status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_data.status);
                  bad = 1'b1;
               end
               if (rsp_data.target_id !== want.target_id) begin
                  $error("target_id expected %0d got %0d", want.target_id,
                         rsp_data.target_id);
                  bad = 1'b1;
               end
               if (rsp_data.out_type !== want.out_type) begin
                  $error("out_type expected %0h got %0h", want.out_type, rsp_data.out_type);
                  bad = 1'b1;
               end
               if (rsp_data.out_size !== want.out_size) begin
                  $error("out_size expected %0h got %0h", want.out_size, rsp_data.out_size);
                  bad = 1'b1;
               end
               if (rsp_data.opened_worker !== want.opened_worker) begin
                  $error("opened_worker expected %0d got %0d", want.opened_worker,
                         rsp_data.opened_worker);
                  bad = 1'b1;
               end
               if (rsp_data.undelivered !== want.undelivered) begin
                  $error("undelivered expected %0d got %0d", want.undelivered,
                         rsp_data.undelivered);
                  bad = 1'b1;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last expected %0d got %0d", want.last, rsp_data.last);
                  bad = 1'b1;
               end
               if (bad) errors++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (pressure_armed && !pressure_done) begin
            pressure_done <= 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int produced;
      int counted;
      int p;
      logic [7:0] plan [5];
      for (int i = 0; i < NUM_WORKERS; i++) begin
         worker_on[i] = 1'b0;
         worker_load[i] = '0;
      end
      cooks_setting = COOKS_RESET;
      plan[0] = 8'd1;
      plan[1] = 8'd3;
      plan[2] = 8'd255;
      plan[3] = 8'($urandom_range(1, 254));
      plan[4] = 8'd1;

      add_op(mk_req(KIND_DONE, 0, 0, 0, 1), 1, mk_rsp(STAT_UNKNOWN, 1, 0, 0, 0, 0));
      add_op(mk_req(KIND_CLOSE, 0, 0, 0, 0), 1, mk_rsp(STAT_UNKNOWN, 0, 0, 0, 0, 0));
      add_op(mk_req(KIND_CLOSE, 255, 255, 127, 31), 1,
             mk_rsp(STAT_UNKNOWN, 31, 0, 0, 0, 0));
      add_op(mk_req(KIND_UNDEF, 255, 255, 127, 31), 0, '0);
      add_op(mk_req(KIND_ORDER, 8'h33, 8'hCC, 0, 5), 0, '0);
      add_op(mk_req(KIND_ORDER, 8'hFF, 8'h00, 1, 0), 1,
             mk_rsp(STAT_DISPATCHED, 1, 8'hFF, 8'h00, 1, 0));
      add_op(mk_req(KIND_DONE, 0, 0, 0, 1), 1, mk_rsp(STAT_APPLIED, 1, 0, 0, 0, 0));
      // load already zero, stays there
      add_op(mk_req(KIND_DONE, 0, 0, 0, 1), 1, mk_rsp(STAT_APPLIED, 1, 0, 0, 0, 0));
      add_op(mk_req(KIND_ORDER, 8'h5A, 8'hA5, 5, 0), 0, '0);
      // oversized order, saturates and overflows the table
      add_op(mk_req(KIND_ORDER, 8'h00, 8'hFF, 127, 31), 0, '0);
      add_op(mk_req(KIND_DONE, 0, 0, 0, 16), 0, '0);
      add_op(mk_req(KIND_CLOSE, 0, 0, 0, 16), 1, mk_rsp(STAT_CLOSED, 16, 0, 0, 0, 0));
      add_cfg(8'd0);
      add_op(mk_req(KIND_ORDER, 8'h12, 8'h34, 3, 0), 1,
             mk_rsp(STAT_DROPPED, 0, 0, 0, 0, 3));
      add_cfg(8'd255);
      add_op(mk_req(KIND_ORDER, 8'h81, 8'h7E, 64, 0), 0, '0);
      add_op(mk_req(KIND_DONE, 0, 0, 0, 0), 1, mk_rsp(STAT_UNKNOWN, 0, 0, 0, 0, 0));
      add_cfg(8'd1);
      add_op(mk_req(KIND_ORDER, 8'hC3, 8'h3C, 2, 0), 0, '0);
      add_op(mk_req(KIND_CLOSE, 0, 0, 0, 2), 0, '0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) write_cooks(dir_rows[i].cooks);
         else send_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp, produced);
      end

      for (p = 0; p < 5; p++) begin
         write_cooks(plan[p]);
         if (p == 0) pressure_armed <= 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            send_item(random_item(), 1'b0, '0, produced);
            if (produced > 0) counted++;
         end
      end

      wait_idle();
      $display("Sent %0d items over %0d cooks settings, incl. zero and 255.", items_sent,
               settings_used);
      $display("Checked %0d results, %0d of them drops.", results_seen, drops_seen);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
